>>> hw/rtl/sac_pkg.sv
// Shared types, constants and helper codes for the shadow alarm controller.
package sac_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int COUNT_BITS    = 16;
  localparam int FRAC_BITS     = 16;
  localparam int BASE_BITS     = SAMPLE_BITS + FRAC_BITS;
  localparam int WEIGHT_BITS   = 16;
  localparam int PROD_A_BITS   = BASE_BITS + WEIGHT_BITS + 1;
  localparam int PROD_B_BITS   = SAMPLE_BITS + WEIGHT_BITS;
  localparam int SUM_BITS      = BASE_BITS + FRAC_BITS + 2;
  localparam int TRIP_BITS     = BASE_BITS + 9;
  localparam int PCT_BITS      = 7;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_LEFT   = 2'd1;
  localparam logic [1:0] REQ_RIGHT  = 2'd2;
  localparam logic [1:0] REQ_SAMPLE = 2'd3;

  localparam logic [CFG_ADDR_BITS-1:0] REG_NEW_WEIGHT   = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SHADOW_PCT   = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CALIB_TICKS  = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CODE_TIMEOUT = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_FLASH_TICKS  = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_BREATHE      = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CALIB_BLINK  = 3'd6;
  localparam logic [CFG_ADDR_BITS-1:0] REG_ALARM_STROBE = 3'd7;

  localparam logic [7:0]  FADE_STEP    = 8'd5;
  localparam logic [7:0]  FADE_TOP     = 8'd150;
  localparam logic [7:0]  FLASH_LEVEL  = 8'd150;
  localparam logic [23:0] COLOR_WHITE  = {FLASH_LEVEL, FLASH_LEVEL, FLASH_LEVEL};
  localparam logic [23:0] COLOR_YELLOW = {8'd100, 8'd80, 8'd0};
  localparam logic [23:0] COLOR_RED    = {8'd255, 8'd0, 8'd0};
  localparam logic [23:0] COLOR_BLUE   = {8'd0, 8'd0, 8'd255};
  localparam logic [23:0] COLOR_OFF    = 24'd0;

  typedef enum logic [1:0] {
    MODE_UNARMED = 2'd0,
    MODE_CALIB   = 2'd1,
    MODE_ARMED   = 2'd2,
    MODE_ALARM   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_SUM,
    ST_TRIP,
    ST_CMP,
    ST_LED,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [SAMPLE_BITS-1:0] light_sample;
  } in_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] code_progress;
    logic       flash_on;
    logic [7:0] led_red;
    logic [7:0] led_green;
    logic [7:0] led_blue;
    logic       alarm_tripped;
  } out_t;

  typedef struct packed {
    logic accept;
    logic eval;
    logic mul;
    logic sum;
    logic trip;
    logic cmp;
    logic led;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic sample_upd;
  } sts_t;

endpackage

>>> hw/rtl/sac_ctrl.sv
// Sequencing state machine and output handshake for the shadow alarm controller.
module sac_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  sac_pkg::sts_t sts,
  output sac_pkg::cmd_t cmd
);

  sac_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != sac_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sac_pkg::ST_IDLE: if (in_valid) state_nxt = sac_pkg::ST_EVAL;
      sac_pkg::ST_EVAL: state_nxt = sts.sample_upd ? sac_pkg::ST_MUL : sac_pkg::ST_LED;
      sac_pkg::ST_MUL:  state_nxt = sac_pkg::ST_SUM;
      sac_pkg::ST_SUM:  state_nxt = sac_pkg::ST_TRIP;
      sac_pkg::ST_TRIP: state_nxt = sac_pkg::ST_CMP;
      sac_pkg::ST_CMP:  state_nxt = sac_pkg::ST_LED;
      sac_pkg::ST_LED:  state_nxt = sac_pkg::ST_DONE;
      sac_pkg::ST_DONE: if (out_free) state_nxt = sac_pkg::ST_IDLE;
      default:          state_nxt = sac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      sac_pkg::ST_IDLE: cmd.accept   = in_valid;
      sac_pkg::ST_EVAL: cmd.eval     = 1'b1;
      sac_pkg::ST_MUL:  cmd.mul      = 1'b1;
      sac_pkg::ST_SUM:  cmd.sum      = 1'b1;
      sac_pkg::ST_TRIP: cmd.trip     = 1'b1;
      sac_pkg::ST_CMP:  cmd.cmp      = 1'b1;
      sac_pkg::ST_LED:  cmd.led      = 1'b1;
      sac_pkg::ST_DONE: cmd.load_out = out_free;
      default:          cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sac_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/sac_datapath.sv
// Mode, timer, baseline and LED datapath of the shadow alarm controller.
module sac_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sac_pkg::cmd_t                        cmd,
  output sac_pkg::sts_t                        sts,
  input  sac_pkg::in_t                         in_data,
  output sac_pkg::out_t                        out_data,
  input  logic                                 cfg_we,
  input  logic [sac_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
  input  logic [sac_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  localparam int CB = sac_pkg::COUNT_BITS;
  localparam int BB = sac_pkg::BASE_BITS;
  localparam int SB = sac_pkg::SAMPLE_BITS;
  localparam int FB = sac_pkg::FRAC_BITS;
  localparam int WB = sac_pkg::WEIGHT_BITS;
  localparam int TB = sac_pkg::TRIP_BITS;

  // configuration
  logic [WB-1:0]                   weight_r;
  logic [sac_pkg::PCT_BITS-1:0]    pct_r;
  logic [CB-1:0] calib_ticks_r, code_to_r, flash_ticks_r, breathe_r, blink_r, strobe_r;

  // item state
  sac_pkg::in_t   req_r;
  sac_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]     step_r, step_nxt;
  logic           flashing_r, flashing_nxt;
  logic [CB-1:0]  calib_el_r, calib_el_nxt;
  logic [CB-1:0]  code_el_r, code_el_nxt;
  logic [CB-1:0]  flash_el_r, flash_el_nxt;
  logic [CB-1:0]  led_el_r, led_el_nxt;
  logic           phase_r, phase_nxt;
  logic [7:0]     bright_r, bright_nxt;
  logic           fade_down_r, fade_down_nxt;
  logic [BB-1:0]  base_r, base_nxt;
  logic           base_valid_r, base_valid_nxt;
  logic [23:0]    color_r, color_nxt;
  logic           tripped_r, tripped_nxt;
  sac_pkg::out_t  out_r;

  // arithmetic pipeline
  logic [sac_pkg::PROD_A_BITS-1:0] prod_a_r;
  logic [sac_pkg::PROD_B_BITS-1:0] prod_b_r;
  logic signed [TB-1:0]            diff100_r;
  logic signed [TB-1:0]            pct_base_r;
  logic [sac_pkg::SUM_BITS-1:0]    sum_w;
  logic [BB-1:0]                   s16_w;
  logic signed [TB-1:0]            diff_w;
  logic [WB:0]                     keep_w;
  logic [7:0]                      bright_w;

  function automatic logic [CB-1:0] bump(input logic [CB-1:0] c);
    bump = (c == sac_pkg::CNT_MAX) ? c : c + 1'b1;
  endfunction

  assign s16_w  = {req_r.light_sample, {FB{1'b0}}};
  assign keep_w = {1'b1, {WB{1'b0}}} - {1'b0, weight_r};
  assign sum_w  = sac_pkg::SUM_BITS'(prod_a_r)
                + sac_pkg::SUM_BITS'({prod_b_r, {FB{1'b0}}})
                + sac_pkg::SUM_BITS'(1 << (FB - 1));
  assign diff_w = TB'($signed({1'b0, base_r})) - TB'($signed({1'b0, s16_w}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r      <= WB'(1311);
      pct_r         <= sac_pkg::PCT_BITS'(20);
      calib_ticks_r <= CB'(2000);
      code_to_r     <= CB'(5000);
      flash_ticks_r <= CB'(150);
      breathe_r     <= CB'(20);
      blink_r       <= CB'(150);
      strobe_r      <= CB'(80);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sac_pkg::REG_NEW_WEIGHT:   weight_r      <= cfg_wdata;
        sac_pkg::REG_SHADOW_PCT:   pct_r         <= cfg_wdata[sac_pkg::PCT_BITS-1:0];
        sac_pkg::REG_CALIB_TICKS:  calib_ticks_r <= cfg_wdata;
        sac_pkg::REG_CODE_TIMEOUT: code_to_r     <= cfg_wdata;
        sac_pkg::REG_FLASH_TICKS:  flash_ticks_r <= cfg_wdata;
        sac_pkg::REG_BREATHE:      breathe_r     <= cfg_wdata;
        sac_pkg::REG_CALIB_BLINK:  blink_r       <= cfg_wdata;
        sac_pkg::REG_ALARM_STROBE: strobe_r      <= cfg_wdata;
        default:                   weight_r      <= weight_r;
      endcase
    end
  end

  always_comb begin
    mode_nxt       = mode_r;
    step_nxt       = step_r;
    flashing_nxt   = flashing_r;
    calib_el_nxt   = calib_el_r;
    code_el_nxt    = code_el_r;
    flash_el_nxt   = flash_el_r;
    led_el_nxt     = led_el_r;
    phase_nxt      = phase_r;
    bright_nxt     = bright_r;
    fade_down_nxt  = fade_down_r;
    base_nxt       = base_r;
    base_valid_nxt = base_valid_r;
    color_nxt      = color_r;
    tripped_nxt    = tripped_r;
    sts.sample_upd = 1'b0;
    bright_w       = bright_r;

    if (cmd.eval) begin
      tripped_nxt = 1'b0;
      case (req_r.req_type)
        sac_pkg::REQ_TICK: begin
          calib_el_nxt = bump(calib_el_r);
          code_el_nxt  = bump(code_el_r);
          flash_el_nxt = bump(flash_el_r);
          led_el_nxt   = bump(led_el_r);
        end
        sac_pkg::REQ_LEFT: begin
          if (mode_r == sac_pkg::MODE_UNARMED) begin
            mode_nxt     = sac_pkg::MODE_CALIB;
            calib_el_nxt = '0;
          end else if (mode_r == sac_pkg::MODE_ALARM) begin
            if (step_r == 2'd0) begin
              step_nxt     = 2'd1;
              code_el_nxt  = '0;
              flashing_nxt = 1'b1;
              flash_el_nxt = '0;
            end else if (step_r == 2'd2) begin
              step_nxt = 2'd0;
              mode_nxt = sac_pkg::MODE_UNARMED;
            end else begin
              step_nxt = 2'd0;
            end
          end
        end
        sac_pkg::REQ_RIGHT: begin
          if (mode_r == sac_pkg::MODE_ARMED) begin
            mode_nxt = sac_pkg::MODE_UNARMED;
          end else if (mode_r == sac_pkg::MODE_ALARM) begin
            if (step_r == 2'd1) begin
              step_nxt     = 2'd2;
              code_el_nxt  = '0;
              flashing_nxt = 1'b1;
              flash_el_nxt = '0;
            end else begin
              step_nxt = 2'd0;
            end
          end
        end
        default: begin
        end
      endcase

      if (mode_nxt == sac_pkg::MODE_CALIB && calib_el_nxt >= calib_ticks_r) begin
        mode_nxt = sac_pkg::MODE_ARMED;
      end
      if (mode_nxt == sac_pkg::MODE_ALARM && step_nxt != 2'd0 && code_el_nxt >= code_to_r) begin
        step_nxt = 2'd0;
      end
      if (flashing_nxt && flash_el_nxt >= flash_ticks_r) begin
        flashing_nxt = 1'b0;
      end

      if (req_r.req_type == sac_pkg::REQ_SAMPLE && mode_nxt == sac_pkg::MODE_ARMED) begin
        if (base_valid_r) begin
          sts.sample_upd = 1'b1;
        end else begin
          base_nxt       = s16_w;
          base_valid_nxt = 1'b1;
        end
      end
    end

    if (cmd.sum) begin
      base_nxt = sum_w[BB+FB-1:FB];
    end

    if (cmd.cmp) begin
      if (base_r != '0 && diff100_r >= pct_base_r) begin
        mode_nxt    = sac_pkg::MODE_ALARM;
        tripped_nxt = 1'b1;
      end
    end

    if (cmd.led) begin
      if (flashing_r) begin
        color_nxt = sac_pkg::COLOR_WHITE;
      end else if (mode_r == sac_pkg::MODE_UNARMED) begin
        color_nxt = sac_pkg::COLOR_OFF;
      end else if (mode_r == sac_pkg::MODE_ARMED) begin
        if (led_el_r >= breathe_r) begin
          led_el_nxt = '0;
          if (fade_down_r) begin
            bright_w = (bright_r >= sac_pkg::FADE_STEP) ? bright_r - sac_pkg::FADE_STEP : 8'd0;
          end else begin
            bright_w = (bright_r <= 8'd255 - sac_pkg::FADE_STEP) ?
                       bright_r + sac_pkg::FADE_STEP : 8'd255;
          end
          bright_nxt = bright_w;
          if (bright_w == 8'd0 || bright_w >= sac_pkg::FADE_TOP) begin
            fade_down_nxt = !fade_down_r;
          end
          color_nxt = {8'd0, bright_w, 8'd0};
        end
      end else if (mode_r == sac_pkg::MODE_CALIB) begin
        if (led_el_r >= blink_r) begin
          led_el_nxt = '0;
          phase_nxt  = !phase_r;
          color_nxt  = !phase_r ? sac_pkg::COLOR_YELLOW : sac_pkg::COLOR_OFF;
        end
      end else begin
        if (led_el_r >= strobe_r) begin
          led_el_nxt = '0;
          phase_nxt  = !phase_r;
          color_nxt  = !phase_r ? sac_pkg::COLOR_RED : sac_pkg::COLOR_BLUE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= sac_pkg::MODE_UNARMED;
      step_r       <= 2'd0;
      flashing_r   <= 1'b0;
      calib_el_r   <= '0;
      code_el_r    <= '0;
      flash_el_r   <= '0;
      led_el_r     <= '0;
      phase_r      <= 1'b0;
      bright_r     <= 8'd0;
      fade_down_r  <= 1'b0;
      base_r       <= '0;
      base_valid_r <= 1'b0;
      color_r      <= sac_pkg::COLOR_OFF;
      tripped_r    <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      step_r       <= step_nxt;
      flashing_r   <= flashing_nxt;
      calib_el_r   <= calib_el_nxt;
      code_el_r    <= code_el_nxt;
      flash_el_r   <= flash_el_nxt;
      led_el_r     <= led_el_nxt;
      phase_r      <= phase_nxt;
      bright_r     <= bright_nxt;
      fade_down_r  <= fade_down_nxt;
      base_r       <= base_nxt;
      base_valid_r <= base_valid_nxt;
      color_r      <= color_nxt;
      tripped_r    <= tripped_nxt;
    end
  end

  // payload and product registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_data;
    end
    if (cmd.mul) begin
      prod_a_r <= sac_pkg::PROD_A_BITS'(base_r * keep_w);
      prod_b_r <= sac_pkg::PROD_B_BITS'(req_r.light_sample * weight_r);
    end
    if (cmd.trip) begin
      diff100_r  <= TB'(diff_w * TB'(100));
      pct_base_r <= $signed(TB'(pct_r * base_r));
    end
    if (cmd.load_out) begin
      out_r.mode          <= mode_r;
      out_r.code_progress <= step_r;
      out_r.flash_on      <= flashing_r;
      out_r.led_red       <= color_r[23:16];
      out_r.led_green     <= color_r[15:8];
      out_r.led_blue      <= color_r[7:0];
      out_r.alarm_tripped <= tripped_r;
    end
  end

  assign out_data = out_r;

endmodule

>>> hw/rtl/shadow_alarm_controller.sv
// Top level of the shadow alarm controller: controller and datapath.
// Each transaction passes through the accept, mode and timer update, LED update and
// output load steps; an armed-mode light sample that updates an already valid baseline
// adds a multiply stage, a sum stage, a scaled-difference multiply stage and a compare
// stage before the LED update. The controller handles one transaction at a time; a new
// one is accepted while the previous result still sits in the output register, and the
// output load stage waits as long as that result is stalled. No clearing pass follows
// reset.
module shadow_alarm_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sac_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sac_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [sac_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [sac_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  sac_pkg::cmd_t cmd;
  sac_pkg::sts_t sts;

  sac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sac_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

endmodule
